@@ sv/rttp_pkg.sv @@
// ----------------------------------------------------------------------------
// rttp_pkg
// Shared types and constants of the periodic tick timer: operation codes,
// field widths, register map and the rate-to-interval table.
// ----------------------------------------------------------------------------
package rttp_pkg;

    localparam int RATE_W      = 7;
    localparam int ACK_W       = 10;
    localparam int CNT_OUT_W   = 10;
    localparam int PHASE_W     = 10;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int ROM_DEPTH   = 128;

    localparam logic [RATE_W-1:0]     MAX_RATE_HZ = 7'd100;
    localparam logic [APB_ADDR_W-1:0] ADDR_RATE   = 3'd0;

    typedef enum logic [1:0] {
        OP_MS_TICK  = 2'd0,
        OP_ACK      = 2'd1,
        OP_CONT_ON  = 2'd2,
        OP_CONT_OFF = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ACK_W-1:0] ack;
    } item_t;

    typedef struct packed {
        logic               restart;
        logic               active;
        logic [PHASE_W-1:0] interval;
    } cfg_t;

    // interval in ms = round(1000 / rate), halves rounded up; rate 0 is idle
    localparam logic [PHASE_W-1:0] INTERVAL_ROM [ROM_DEPTH] = '{
        10'd0,   10'd1000, 10'd500, 10'd333, 10'd250, 10'd200, 10'd167, 10'd143,
        10'd125, 10'd111,  10'd100, 10'd91,  10'd83,  10'd77,  10'd71,  10'd67,
        10'd63,  10'd59,   10'd56,  10'd53,  10'd50,  10'd48,  10'd45,  10'd43,
        10'd42,  10'd40,   10'd38,  10'd37,  10'd36,  10'd34,  10'd33,  10'd32,
        10'd31,  10'd30,   10'd29,  10'd29,  10'd28,  10'd27,  10'd26,  10'd26,
        10'd25,  10'd24,   10'd24,  10'd23,  10'd23,  10'd22,  10'd22,  10'd21,
        10'd21,  10'd20,   10'd20,  10'd20,  10'd19,  10'd19,  10'd19,  10'd18,
        10'd18,  10'd18,   10'd17,  10'd17,  10'd17,  10'd16,  10'd16,  10'd16,
        10'd16,  10'd15,   10'd15,  10'd15,  10'd15,  10'd14,  10'd14,  10'd14,
        10'd14,  10'd14,   10'd14,  10'd13,  10'd13,  10'd13,  10'd13,  10'd13,
        10'd13,  10'd12,   10'd12,  10'd12,  10'd12,  10'd12,  10'd12,  10'd11,
        10'd11,  10'd11,   10'd11,  10'd11,  10'd11,  10'd11,  10'd11,  10'd11,
        10'd10,  10'd10,   10'd10,  10'd10,  10'd10,  10'd10,  10'd10,  10'd10,
        10'd10,  10'd10,   10'd9,   10'd9,   10'd9,   10'd9,   10'd9,   10'd9,
        10'd9,   10'd9,    10'd9,   10'd9,   10'd9,   10'd9,   10'd8,   10'd8,
        10'd8,   10'd8,    10'd8,   10'd8,   10'd8,   10'd8,   10'd8,   10'd8
    };

endpackage

@@ sv/rttp_cfg.sv @@
// ----------------------------------------------------------------------------
// rttp_cfg
// APB register file: holds the rate, looks up the tick interval on write and
// signals a phase restart.
// ----------------------------------------------------------------------------
module rttp_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rttp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rttp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rttp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output rttp_pkg::cfg_t                     cfg
);
    import rttp_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    logic [RATE_W-1:0]  rate_next;
    logic [PHASE_W-1:0] interval_reg;
    logic [PHASE_W-1:0] interval_next;
    logic               sel_rate;
    logic               wr_ok;
    logic [RATE_W-1:0]  wr_rate;

    assign pready   = 1'b1;
    assign sel_rate = (paddr[APB_ADDR_W-1:2] == ADDR_RATE[APB_ADDR_W-1:2]);
    assign wr_rate  = pwdata[RATE_W-1:0];
    // drop rates above the maximum
    assign wr_ok    = psel && penable && pwrite && pready && sel_rate
                      && (wr_rate <= MAX_RATE_HZ);

    always_comb begin
        rate_next     = rate_reg;
        interval_next = interval_reg;
        if (wr_ok) begin
            rate_next     = wr_rate;
            interval_next = INTERVAL_ROM[wr_rate];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg     <= '0;
            interval_reg <= '0;
        end else begin
            rate_reg     <= rate_next;
            interval_reg <= interval_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_rate) begin
            prdata = APB_DATA_W'(rate_reg);
        end
    end

    assign cfg.restart  = wr_ok;
    assign cfg.active   = (rate_reg != '0);
    assign cfg.interval = interval_reg;

endmodule

@@ sv/rttp_in_stage.sv @@
// ----------------------------------------------------------------------------
// rttp_in_stage
// Input register: captures one word from the input channel and holds it until
// the core takes it.
// ----------------------------------------------------------------------------
module rttp_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [rttp_pkg::ACK_W-1:0]    s_ack_count,
    output rttp_pkg::item_t               item,
    output logic                          item_valid,
    input  logic                          item_take
);
    import rttp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    assign s_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (item_take) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next   = 1'b1;
            item_next.op = op_t'(s_operation);
            item_next.ack = s_ack_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

@@ sv/rttp_core.sv @@
// ----------------------------------------------------------------------------
// rttp_core
// Timer state and result register: advances the phase, updates the pending
// count and continuous mode, and registers one result word per item.
// ----------------------------------------------------------------------------
module rttp_core #(
    parameter int PENDING_MAX = 1023
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rttp_pkg::cfg_t                   cfg,
    input  rttp_pkg::item_t                  item,
    input  logic                             item_valid,
    output logic                             item_take,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rttp_pkg::CNT_OUT_W-1:0]   m_pending_count,
    output logic                             m_event_kind,
    output logic                             m_tick_fired,
    output logic                             m_saturated
);
    import rttp_pkg::*;

    localparam int PW = $clog2(PENDING_MAX + 1);
    localparam int CW = PW + ACK_W;
    localparam logic [PW-1:0] CNT_MAX = PW'(PENDING_MAX);

    logic [PHASE_W-1:0]        phase_reg;
    logic [PHASE_W-1:0]        phase_next;
    logic [PW-1:0]             pend_reg;
    logic [PW-1:0]             pend_next;
    logic                      mode_reg;
    logic                      mode_next;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [CNT_OUT_W-1:0]      m_count_reg;
    logic                      m_kind_reg;
    logic                      m_fired_reg;
    logic                      m_sat_reg;

    logic [PHASE_W:0]          phase_inc;
    logic [PW-1:0]             avail;
    logic [PW-1:0]             pend_sub;
    logic [PW-1:0]             pend_add;
    logic                      full;
    logic                      do_add;
    logic                      fired;
    logic                      sat;
    logic [PW+CNT_OUT_W-1:0]   pend_wide;

    assign item_take = item_valid && (!m_valid_reg || m_ready);

    assign full      = (pend_reg >= CNT_MAX);
    assign pend_add  = full ? CNT_MAX : pend_reg + 1'b1;
    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign avail     = (mode_reg && pend_reg != '0) ? pend_reg - 1'b1 : pend_reg;

    always_comb begin
        if (CW'(item.ack) > CW'(avail)) begin
            pend_sub = pend_reg - avail;
        end else begin
            pend_sub = PW'(CW'(pend_reg) - CW'(item.ack));
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        mode_next  = mode_reg;
        do_add     = 1'b0;
        fired      = 1'b0;
        if (item_take) begin
            case (item.op)
                OP_MS_TICK: begin
                    if (cfg.active) begin
                        if (phase_inc >= {1'b0, cfg.interval}) begin
                            phase_next = '0;
                            fired      = 1'b1;
                            do_add     = 1'b1;
                        end else begin
                            phase_next = phase_inc[PHASE_W-1:0];
                        end
                    end
                end
                OP_ACK: begin
                    pend_next = pend_sub;
                end
                OP_CONT_ON: begin
                    if (!mode_reg) begin
                        mode_next = 1'b1;
                        do_add    = 1'b1;
                    end
                end
                OP_CONT_OFF: begin
                    if (mode_reg) begin
                        mode_next = 1'b0;
                        if (pend_reg != '0) begin
                            pend_next = pend_reg - 1'b1;
                        end
                    end
                end
                default: begin
                    pend_next = pend_reg;
                end
            endcase
        end
        if (do_add) begin
            pend_next = pend_add;
        end
        sat = do_add && full;
        // restart phase on a rate write
        if (cfg.restart) begin
            phase_next = '0;
        end
    end

    assign pend_wide = {{CNT_OUT_W{1'b0}}, pend_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (item_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            pend_reg    <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pend_reg    <= pend_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            m_count_reg <= pend_wide[CNT_OUT_W-1:0];
            m_kind_reg  <= mode_next && (pend_next == PW'(1));
            m_fired_reg <= fired;
            m_sat_reg   <= sat;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pending_count = m_count_reg;
    assign m_event_kind    = m_kind_reg;
    assign m_tick_fired    = m_fired_reg;
    assign m_saturated     = m_sat_reg;

endmodule

@@ sv/rate_tick_timer_pending.sv @@
// ----------------------------------------------------------------------------
// rate_tick_timer_pending
// Periodic tick timer with a saturating count of pending ticks. Each input
// word is a one-millisecond step, an acknowledge, or a continuous-mode
// enable or disable, and yields exactly one result word with the pending
// count, the event kind, whether a tick fired and whether an increment was
// lost to saturation. The rate register (APB, offset 0) selects ticks per
// second; the interval is round(1000 / rate) ms from a table, and any
// accepted rate write restarts the phase. One word is taken every cycle
// while the result is not stalled; each word passes through the input
// register and is then written, with the state update done in a single
// pass, into the result register. A stalled result holds the input
// register, and the input stalls once both registers are full.
// ----------------------------------------------------------------------------
module rate_tick_timer_pending #(
    parameter int PENDING_MAX = 1023
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rttp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rttp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rttp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [rttp_pkg::ACK_W-1:0]         s_ack_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rttp_pkg::CNT_OUT_W-1:0]     m_pending_count,
    output logic                               m_event_kind,
    output logic                               m_tick_fired,
    output logic                               m_saturated
);
    import rttp_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;

    rttp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rttp_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_ack_count (s_ack_count),
        .item        (item),
        .item_valid  (item_valid),
        .item_take   (item_take)
    );

    rttp_core #(
        .PENDING_MAX (PENDING_MAX)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .item            (item),
        .item_valid      (item_valid),
        .item_take       (item_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pending_count (m_pending_count),
        .m_event_kind    (m_event_kind),
        .m_tick_fired    (m_tick_fired),
        .m_saturated     (m_saturated)
    );

endmodule

@@ sv/rttp_checker.sv @@
// ----------------------------------------------------------------------------
// rttp_checker
// Port-level checks of the tick timer, bound to the top level.
// ----------------------------------------------------------------------------
module rttp_checker #(
    parameter int PENDING_MAX = 1023
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [rttp_pkg::CNT_OUT_W-1:0]     m_pending_count,
    input logic                               m_event_kind,
    input logic                               m_tick_fired,
    input logic                               m_saturated
);
    import rttp_pkg::*;

    localparam int PW = $clog2(PENDING_MAX + 1);
    localparam logic [PW+CNT_OUT_W-1:0] MAX_WIDE = (PW + CNT_OUT_W)'(PENDING_MAX);
    localparam logic [CNT_OUT_W-1:0] MAX_SHOWN = MAX_WIDE[CNT_OUT_W-1:0];

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pending_count)
            && $stable(m_event_kind) && $stable(m_tick_fired) && $stable(m_saturated))
        else $error("stalled result word changed");

    a_sat_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_pending_count == MAX_SHOWN)
        else $error("saturated word without full pending count");

    a_cont_one_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind |-> m_pending_count == CNT_OUT_W'(1))
        else $error("continuous event without exactly one pending tick");

endmodule

bind rate_tick_timer_pending rttp_checker #(
    .PENDING_MAX (PENDING_MAX)
) u_rttp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pending_count (m_pending_count),
    .m_event_kind    (m_event_kind),
    .m_tick_fired    (m_tick_fired),
    .m_saturated     (m_saturated)
);
